// ===== sv/cfl_pkg.sv =====
// ----------------------------------------------------------------------------
// cfl_pkg
// Shared types and constants of the centered FIR low-pass unit.
// ----------------------------------------------------------------------------
package cfl_pkg;

  // filter size and derived widths
  localparam int MAX_TAPS = 256;
  localparam int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 8;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
  localparam int ACC_W    = PROD_W + CNT_W;

  // configuration registers
  localparam int TAP_W   = 9;
  localparam int DELAY_W = 8;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_DELAY = 1'd1;
  localparam logic [TAP_W-1:0]   TAP_COUNT_RESET    = 9'd151;
  localparam logic [DELAY_W-1:0] CENTER_DELAY_RESET = 8'd75;

  // item operations
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e                        operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [INDEX_W-1:0]         coef_index;
    logic [COEF_W-1:0]          coef_value;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       saturated;
  } out_t;

  // control from sequencer to multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

endpackage

// ===== sv/cfl_ram.sv =====
// ----------------------------------------------------------------------------
// cfl_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cfl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cfl_mac.sv =====
// ----------------------------------------------------------------------------
// cfl_mac
// Two-stage multiply-accumulate with Q1.15 rounding and 16-bit saturation.
// ----------------------------------------------------------------------------
module cfl_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfl_pkg::mac_ctl_t                   ctl_i,
  input  logic signed [cfl_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [cfl_pkg::COEF_W-1:0]          coef_i,
  output logic                                busy_o,
  output cfl_pkg::out_t                       res_o
);
  import cfl_pkg::*;

  localparam int RW = ACC_W + 1 - FRAC_W;
  localparam logic signed [ACC_W:0]  ROUND_HALF = (ACC_W+1)'(1 << (FRAC_W - 1));
  localparam logic signed [RW-1:0]   RES_MAX = RW'(32767);
  localparam logic signed [RW-1:0]   RES_MIN = -RW'(32768);

  logic signed [PROD_W-1:0] prod_q;
  logic                     pv_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W:0]    biased;
  logic signed [RW-1:0]     rounded;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= sample_i * $signed({1'b0, coef_i});
    end
  end

  // accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // round half up, then clip to 16 bits
  always_comb begin
    biased  = (ACC_W+1)'(acc_q) + ROUND_HALF;
    rounded = $signed(biased[ACC_W:FRAC_W]);
    if (rounded > RES_MAX) begin
      res_o.filtered_sample = SAMPLE_W'(RES_MAX);
      res_o.saturated       = 1'b1;
    end else if (rounded < RES_MIN) begin
      res_o.filtered_sample = SAMPLE_W'(RES_MIN);
      res_o.saturated       = 1'b1;
    end else begin
      res_o.filtered_sample = SAMPLE_W'(rounded);
      res_o.saturated       = 1'b0;
    end
  end

  assign busy_o = pv_q;

endmodule

// ===== sv/centered_fir_lowpass_unit.sv =====
// ----------------------------------------------------------------------------
// centered_fir_lowpass_unit
// FIR low-pass with zero padding and a centering delay, memory based.
// ----------------------------------------------------------------------------
// Items enter on in_valid_i / in_stall_o / in_data_i and results leave on
// out_valid_o / out_stall_i / out_data_o; a transfer happens when valid is
// high and stall is low. Config registers are written through cfg_we_i,
// cfg_index_i (0 tap count, 1 center delay) and cfg_data_i; the user must
// write them only while idle, as the block itself does not enforce it.
// Load-coefficient and restart items, and sample or flush items inside the
// warm-up window, leave the input free; the latter give no result. Past the
// warm-up window an item runs one multiply-accumulate per tap, paced by the
// single read port of the delay-line and coefficient RAMs, then a short
// pipeline drain and the output load.
// The finished result sits in an output register, so a new item is taken
// while it waits; if the receiver still stalls when the next result is
// ready, the unit holds in its finish state with in_stall_o high.
// Reset clears the delay line at once through per-entry valid bits, zeroes
// the warm-up count and loads the default tap count and center delay.
// Coefficients are not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module centered_fir_lowpass_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cfl_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cfl_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [cfl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cfl_pkg::CFG_W-1:0]         cfg_data_i
);
  import cfl_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_TAPS - 1);
  localparam int IDX_EXT_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;

  state_e               state_q, state_d;
  logic [TAP_W-1:0]     tap_cfg_q;
  logic [DELAY_W-1:0]   delay_cfg_q;
  logic [ADDR_W-1:0]    wptr_q, wptr_d, wptr_inc;
  logic [ADDR_W-1:0]    rptr_q, rptr_d, rptr_dec;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     taps_q, taps_d, taps_sat;
  logic [DELAY_W-1:0]   warm_q, warm_d;
  logic [MAX_TAPS-1:0]  lv_q, lv_d;
  logic                 lvr_q;
  logic                 issue_q;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_data_q, out_data_d;

  logic                 accept, shift_item, start_mac;
  logic                 issue_en, out_load;
  logic [IDX_EXT_W-1:0] coef_idx_ext;
  logic                 coef_we;
  logic [SAMPLE_W-1:0]  line_wdata, line_rdata;
  logic [COEF_W-1:0]    coef_rdata;
  logic signed [SAMPLE_W-1:0] mac_sample;
  mac_ctl_t             mac_ctl;
  logic                 mac_busy;
  out_t                 mac_res;

  // input handshake and item decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign shift_item = accept && (in_data_i.operation == OP_SAMPLE ||
                                 in_data_i.operation == OP_FLUSH);
  assign start_mac  = shift_item && (warm_q >= delay_cfg_q);

  assign wptr_inc = (wptr_q == LAST_ADDR) ? '0 : wptr_q + 1'b1;
  assign rptr_dec = (rptr_q == '0) ? LAST_ADDR : rptr_q - 1'b1;
  assign taps_sat = (32'(tap_cfg_q) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_cfg_q);

  assign coef_idx_ext = IDX_EXT_W'(in_data_i.coef_index);
  assign coef_we      = accept && (in_data_i.operation == OP_LOAD) &&
                        (32'(coef_idx_ext) < 32'(MAX_TAPS));
  assign line_wdata   = (in_data_i.operation == OP_SAMPLE) ? in_data_i.sample_value : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cfg_q   <= TAP_COUNT_RESET;
      delay_cfg_q <= CENTER_DELAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TAP_COUNT:    tap_cfg_q   <= cfg_data_i[TAP_W-1:0];
        CFG_CENTER_DELAY: delay_cfg_q <= cfg_data_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_mac) state_d = ST_MAC;
      ST_MAC:    if (cnt_q >= taps_q) state_d = ST_DRAIN;
      ST_DRAIN:  if (!issue_q && !mac_busy) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    issue_en      = 1'b0;
    out_load      = 1'b0;
    mac_ctl.clear = 1'b0;
    case (state_q)
      ST_IDLE:   mac_ctl.clear = start_mac;
      ST_MAC:    issue_en = (cnt_q < taps_q);
      ST_DRAIN:  ;
      ST_FINISH: out_load = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
    mac_ctl.valid = issue_q;
  end

  // pointers, counters and delay-line valid bits
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    taps_d = taps_q;
    warm_d = warm_q;
    lv_d   = lv_q;
    if (accept && in_data_i.operation == OP_RESTART) begin
      lv_d   = '0;
      warm_d = '0;
    end
    if (shift_item) begin
      wptr_d         = wptr_inc;
      lv_d[wptr_inc] = 1'b1;
      if (warm_q < delay_cfg_q) begin
        warm_d = warm_q + 1'b1;
      end else begin
        rptr_d = wptr_inc;
        cnt_d  = '0;
        taps_d = taps_sat;
      end
    end
    if (issue_en) begin
      cnt_d  = cnt_q + 1'b1;
      rptr_d = rptr_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
      taps_q  <= '0;
      warm_q  <= '0;
      lv_q    <= '0;
      issue_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      cnt_q   <= cnt_d;
      taps_q  <= taps_d;
      warm_q  <= warm_d;
      lv_q    <= lv_d;
      issue_q <= issue_en;
    end
  end

  // valid bit of the entry being read, aligned with the RAM data
  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      lvr_q <= lv_q[rptr_q];
    end
  end

  // delay-line and coefficient memories
  cfl_ram #(.DEPTH(MAX_TAPS), .WIDTH(SAMPLE_W)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (shift_item),
    .waddr_i (wptr_inc),
    .wdata_i (line_wdata),
    .re_i    (issue_en),
    .raddr_i (rptr_q),
    .rdata_o (line_rdata)
  );

  cfl_ram #(.DEPTH(MAX_TAPS), .WIDTH(COEF_W)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (ADDR_W'(coef_idx_ext)),
    .wdata_i (in_data_i.coef_value),
    .re_i    (issue_en),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (coef_rdata)
  );

  // entries not written since restart read as zero
  assign mac_sample = lvr_q ? $signed(line_rdata) : '0;

  cfl_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (mac_sample),
    .coef_i   (coef_rdata),
    .busy_o   (mac_busy),
    .res_o    (mac_res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = mac_res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/cfl_checker.sv =====
// ----------------------------------------------------------------------------
// cfl_checker
// Port-level checks of the centered FIR low-pass unit, bound to the top.
// ----------------------------------------------------------------------------
module cfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input cfl_pkg::in_t                  in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input cfl_pkg::out_t                 out_data_o
);
  import cfl_pkg::*;

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // load and restart transfers leave the unit free to take an item in the next cycle
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.operation == OP_LOAD || in_data_i.operation == OP_RESTART)
    |=> !in_stall_o)
    else $error("load or restart kept the unit busy");

  // a new result only comes out of a filter pass
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a filter pass");

  // the clip flag matches a range limit
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
    (out_data_o.filtered_sample == 16'sh7fff || out_data_o.filtered_sample == 16'sh8000))
    else $error("clip flag without a limit value");

endmodule

bind centered_fir_lowpass_unit cfl_checker u_cfl_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the centered FIR low-pass unit.
// ----------------------------------------------------------------------------
// Loads every tap weight, then runs a short directed set: unit and
// above-unit weights, full-scale samples, positive and negative clipping,
// half-way rounding, flushes, restarts and a zero tap count. After that come
// random phases over several tap counts and centering delays: the two extremes,
// tap counts past the filter size, and a few sender and receiver idle mixes.
// Random traffic is mostly restart / sample run / flush sequences with random
// content, plus some raw items. A mirror of the filter state predicts every
// output, and outputs are checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import cfl_pkg::*;

  localparam int SETTLE_CYCLES = MAX_TAPS + 16;
  localparam int CYCLE_LIMIT   = 2000000;

  // filter state mirror and queue of predicted outputs
  class centered_fir_mirror;
    logic [TAP_W-1:0]           tap_count;
    logic [DELAY_W-1:0]         center_delay;
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
    logic [COEF_W-1:0]          weights [MAX_TAPS];
    int unsigned                warmup;
    out_t                       pending_outputs [$];

    function void clear_state();
      tap_count    = TAP_COUNT_RESET;
      center_delay = CENTER_DELAY_RESET;
      foreach (history[k]) history[k] = '0;
      foreach (weights[k]) weights[k] = '0;
      warmup = 0;
      pending_outputs.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_TAP_COUNT) tap_count = data[TAP_W-1:0];
      else if (idx == CFG_CENTER_DELAY) center_delay = data[DELAY_W-1:0];
    endfunction

    // one accepted input transfer
    function void take_item(in_t it);
      int    taps;
      longint acc;
      longint rounded;
      out_t  want;
      case (it.operation)
        OP_LOAD: begin
          weights[it.coef_index] = it.coef_value;
        end
        OP_RESTART: begin
          foreach (history[k]) history[k] = '0;
          warmup = 0;
        end
        default: begin
          for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
          history[0] = (it.operation == OP_SAMPLE) ? it.sample_value : '0;
          if (warmup < center_delay) begin
            warmup++;
          end else begin
            taps = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
            acc  = 0;
            for (int k = 0; k < taps; k++)
              acc += longint'(history[k]) * longint'(weights[k]);
            // round half up at Q1.15, then clip to 16 bits
            rounded = (acc + 64'sd16384) >>> FRAC_W;
            want.saturated = 1'b0;
            if (rounded > 32767) begin
              rounded = 32767;
              want.saturated = 1'b1;
            end else if (rounded < -32768) begin
              rounded = -32768;
              want.saturated = 1'b1;
            end
            want.filtered_sample = rounded[SAMPLE_W-1:0];
            pending_outputs = {pending_outputs, want};
          end
        end
      endcase
    endfunction

    // empty string when the output transfer matches
    function string compare_output(out_t got);
      out_t  want;
      string msg;
      msg = "";
      if (pending_outputs.size() == 0)
        return $sformatf("output %0d/%0b with nothing predicted",
                         got.filtered_sample, got.saturated);
      want = pending_outputs.pop_front();
      if (got.filtered_sample !== want.filtered_sample)
        msg = $sformatf("filtered_sample got %0d want %0d ",
                        got.filtered_sample, want.filtered_sample);
      if (got.saturated !== want.saturated)
        msg = {msg, $sformatf("saturated got %0b want %0b",
                              got.saturated, want.saturated)};
      return msg;
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  in_t                    in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_t                   out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i  = '0;

  centered_fir_mirror mirror;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycles         = 0;

  centered_fir_lowpass_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 200) $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  // output side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin : drain_outputs
    string note;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      note = mirror.compare_output(out_data_o);
      if (note != "") flag_mismatch(note);
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_t random_item();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_t)-1:0];
  endfunction

  function automatic in_t shaped(op_e op, logic [SAMPLE_W-1:0] sample,
                                 logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
    in_t it;
    it.operation    = op;
    it.sample_value = sample;
    it.coef_index   = idx;
    it.coef_value   = val;
    return it;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return '0;
      2:       return COEF_W'($urandom);
      default: return COEF_W'($urandom_range(0, 2048));
    endcase
  endfunction

  // input side: optional gap, then hold the item until it transfers
  task automatic push_item(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    mirror.take_item(it);
  endtask

  task automatic push_op(op_e op);
    push_item(shaped(op, SAMPLE_W'($urandom), INDEX_W'($urandom), COEF_W'($urandom)));
  endtask

  task automatic push_sample(logic [SAMPLE_W-1:0] v);
    push_item(shaped(OP_SAMPLE, v, INDEX_W'($urandom), COEF_W'($urandom)));
  endtask

  task automatic push_load(logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
    push_item(shaped(OP_LOAD, SAMPLE_W'($urandom), idx, val));
  endtask

  // wait for every predicted output, then for any result-free work to end
  task automatic settle();
    while (mirror.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers back to back, write enable held across the pair
  task automatic write_config(logic [TAP_W-1:0] taps, logic [DELAY_W-1:0] delay);
    logic [CFG_W-1:0] delay_word;
    delay_word = {1'($urandom_range(1)), delay};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_TAP_COUNT;
    cfg_data_i  <= taps;
    @(posedge clk_i);
    mirror.write_reg(CFG_TAP_COUNT, taps);
    cfg_index_i <= CFG_CENTER_DELAY;
    cfg_data_i  <= delay_word;
    @(posedge clk_i);
    mirror.write_reg(CFG_CENTER_DELAY, delay_word);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly restart / sample run / flush tail sequences, some raw items
  task automatic run_random(int budget, int delay);
    int left;
    int n;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(99) < 10) begin
        push_item(random_item());
        left--;
      end else begin
        push_op(OP_RESTART);
        left--;
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) push_load(INDEX_W'($urandom), pick_weight());
        left -= n;
        // some runs stop inside the warm-up window
        n = ($urandom_range(3) == 0) ? $urandom_range(0, delay)
                                     : delay + $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(19) == 0) begin
            push_load(INDEX_W'($urandom), pick_weight());
            left--;
          end
          push_sample(pick_sample());
          left--;
        end
        n = $urandom_range(0, 12);
        for (int i = 0; i < n; i++) push_op(OP_FLUSH);
        left -= n;
      end
    end
  endtask

  task automatic run_phase(logic [TAP_W-1:0] taps, logic [DELAY_W-1:0] delay,
                           int s_pct, int r_pct, int budget);
    settle();
    write_config(taps, delay);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    run_random(budget, int'(delay));
    in_valid_i <= 1'b0;
  endtask

  initial begin
    mirror = new();
    mirror.clear_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every tap weight defined before any output is computed
    for (int i = 0; i < MAX_TAPS; i++)
      push_load(i[INDEX_W-1:0], COEF_W'($urandom_range(0, 1024)));
    in_valid_i <= 1'b0;

    // three taps, no centering: unit and above-unit weights, clipping
    settle();
    write_config(9'd3, 8'd0);
    push_load(8'd0, 16'h8000);
    push_load(8'd1, 16'hFFFF);
    push_load(8'd2, 16'h8001);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_sample(16'h8000);
    push_op(OP_FLUSH);
    push_op(OP_FLUSH);
    // half-way sums round toward plus infinity
    push_op(OP_RESTART);
    push_load(8'd0, 16'h4000);
    push_load(8'd1, 16'h0000);
    push_load(8'd2, 16'h0000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    in_valid_i <= 1'b0;

    // zero taps behind a short warm-up
    settle();
    write_config(9'd0, 8'd2);
    push_op(OP_RESTART);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h1234);
    push_op(OP_FLUSH);
    for (int i = 0; i < 3; i++)
      push_load(i[INDEX_W-1:0], COEF_W'($urandom_range(0, 1024)));
    in_valid_i <= 1'b0;

    // random phases
    run_phase(9'd1,   8'd0,   0,  0,  150);
    run_phase(9'd8,   8'd3,   47, 0,  150);
    run_phase(9'd0,   8'd5,   0,  47, 80);
    run_phase(9'd16,  8'd12,  22, 22, 150);
    run_phase(9'd151, 8'd75,  0,  0,  200);
    run_phase(9'd256, 8'd255, 22, 22, 200);
    run_phase(9'd300, 8'd20,  0,  47, 100);
    run_phase(9'd511, 8'd0,   47, 0,  70);
    run_phase(9'd4,   8'd1,   22, 22, 150);

    settle();
    if (mismatch_count == 0 && mirror.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
